// ===== design/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared definitions for the height-map 3x3 box smoothing unit
// Sizes, register indexes, the divide-by-nine reciprocal and the result slot
// type used by the output stage.
// ----------------------------------------------------------------------------
package hbs_pkg;

    // Map limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 8;
    localparam int SIZE_W   = 11;
    localparam int HEIGHT_W = 16;
    localparam int SUM_W    = 12;   // nine 8-bit samples
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] MAX_W_SIZE    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SIZE    = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] RESET_SIZE    = SIZE_W'(256);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

    // floor(sum*256/9) = (sum * DIV9_MUL) >> DIV9_SHIFT, exact for sum < 2^12
    localparam int DIV9_MUL_W = 20;
    localparam int PROD_W     = SUM_W + DIV9_MUL_W;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(932068);
    localparam int DIV9_SHIFT = 15;

    // One pending result of the output stage
    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [HEIGHT_W-1:0] height;
        logic                border;
    } res_slot_t;

endpackage

// ===== design/heightmap_box_smoothing_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// heightmap_box_smoothing_3x3_unit: 3x3 box smoothing of a raster height map
// Pipeline: a sample passes stage 1, stage 2 and the output stage in turn;
// further results of the same sample follow one per cycle while out_stall is low.
// Throughput: one sample per cycle while out_stall is low; a sample that releases two
// or three results holds the input until the last of them is taken (one output port).
// Reset: counters and window cleared, sizes 256, pipeline empty; line stores
// are not cleared and hold no valid data until written.
// ----------------------------------------------------------------------------
module heightmap_box_smoothing_3x3_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbs_pkg::SIZE_W-1:0]     cfg_data,
    // sample input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hbs_pkg::SAMPLE_W-1:0]   sample,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hbs_pkg::COL_W-1:0]      column,
    output logic [hbs_pkg::ROW_W-1:0]      row,
    output logic [hbs_pkg::HEIGHT_W-1:0]   height_fixed,
    output logic                           is_border,
    output logic                           last
);
    import hbs_pkg::*;

    // Configuration and position state
    logic [SIZE_W-1:0] map_width_reg, map_height_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic              cfg_fire, cfg_hit;

    // Line stores and read data
    logic [SAMPLE_W-1:0] line_older_reg [MAX_WIDTH];
    logic [SAMPLE_W-1:0] line_newer_reg [MAX_WIDTH];
    logic [SAMPLE_W-1:0] rd_older_reg, rd_newer_reg;

    // Window: [0..2] column x-2, [3..5] column x-1 (top, mid, bottom)
    logic [SAMPLE_W-1:0] win_reg [6];

    // Stage 1: accepted sample
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [COL_W-1:0]    s1_x_reg;
    logic [ROW_W-1:0]    s1_y_reg;

    // Stage 2: window sum and result set
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [2:0]          s2_mask_reg;
    logic                s2_interior_reg;
    res_slot_t           s2_slot_reg [3];
    res_slot_t           s2_res0;

    // Output stage
    logic [2:0]          pend_reg, pend_next;
    res_slot_t           res_slot_reg [3];
    res_slot_t           out_slot;

    // Handshake and flow control
    logic in_fire, out_fire, out_free, s2_move, s2_free, s1_move;

    // Stage 1 combinational results
    logic [SUM_W-1:0]    s1_sum;
    logic [2:0]          s1_mask;
    logic                s1_interior;
    res_slot_t           s1_slot [3];
    logic                s1_first_col, s1_last_col;

    // Divide by nine
    logic [PROD_W-1:0]   div_prod;
    logic [HEIGHT_W-1:0] div_quot;

    // Effective map size, clamped to 3..MAX
    always_comb
    begin
        if (map_width_reg < MIN_SIZE)
            w_eff = MIN_SIZE;
        else if (map_width_reg > MAX_W_SIZE)
            w_eff = MAX_W_SIZE;
        else
            w_eff = map_width_reg;
        if (map_height_reg < MIN_SIZE)
            h_eff = MIN_SIZE;
        else if (map_height_reg > MAX_H_SIZE)
            h_eff = MAX_H_SIZE;
        else
            h_eff = map_height_reg;
    end

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_fire && (cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT);

    // Flow control
    assign out_fire = out_valid && !out_stall;
    assign out_free = (pend_reg == 3'b000) || (out_fire && (pend_next == 3'b000));
    assign s2_move  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_fire  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= RESET_SIZE;
            map_height_reg <= RESET_SIZE;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Raster position of the next sample
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (in_fire)
        begin
            if (({1'b0, col_cnt_reg} + SIZE_W'(1)) >= w_eff)
            begin
                col_cnt_next = '0;
                if (({1'b0, row_cnt_reg} + SIZE_W'(1)) >= h_eff)
                    row_cnt_next = '0;
                else
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
            end
            else
                col_cnt_next = col_cnt_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line stores: read on transaction, write back when stage 1 retires
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_older_reg <= line_older_reg[col_cnt_reg];
            rd_newer_reg <= line_newer_reg[col_cnt_reg];
        end
        if (s1_move)
        begin
            line_older_reg[s1_x_reg] <= rd_newer_reg;
            line_newer_reg[s1_x_reg] <= s1_sample_reg;
        end
    end

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= sample;
            s1_x_reg      <= col_cnt_reg;
            s1_y_reg      <= row_cnt_reg;
        end
    end

    // Window sum and the set of released results
    always_comb
    begin
        s1_sum = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2])
               + SUM_W'(win_reg[3]) + SUM_W'(win_reg[4]) + SUM_W'(win_reg[5])
               + SUM_W'(rd_older_reg) + SUM_W'(rd_newer_reg) + SUM_W'(s1_sample_reg);

        s1_first_col = (s1_x_reg == COL_W'(1));
        s1_last_col  = ({1'b0, s1_x_reg} == (w_eff - SIZE_W'(1)));

        s1_mask[0] = (s1_y_reg != '0) && (s1_x_reg != '0);
        s1_mask[1] = (s1_y_reg != '0) && s1_last_col;
        s1_mask[2] = ({1'b0, s1_y_reg} == (h_eff - SIZE_W'(1)));

        // neighbourhood centre one row and one column back
        s1_interior = !s1_first_col && (s1_y_reg != ROW_W'(1));

        s1_slot[0].col    = s1_x_reg - COL_W'(1);
        s1_slot[0].row    = s1_y_reg - ROW_W'(1);
        s1_slot[0].height = {win_reg[4], 8'h00};
        s1_slot[0].border = !s1_interior;

        // right-hand edge of the previous row
        s1_slot[1].col    = s1_x_reg;
        s1_slot[1].row    = s1_y_reg - ROW_W'(1);
        s1_slot[1].height = {rd_newer_reg, 8'h00};
        s1_slot[1].border = 1'b1;

        // last row passes straight through
        s1_slot[2].col    = s1_x_reg;
        s1_slot[2].row    = s1_y_reg;
        s1_slot[2].height = {s1_sample_reg, 8'h00};
        s1_slot[2].border = 1'b1;
    end

    // Window shift on stage 1 retire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_move)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= rd_older_reg;
            win_reg[4] <= rd_newer_reg;
            win_reg[5] <= s1_sample_reg;
        end
    end

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_move)
            s2_valid_reg <= 1'b1;
        else if (s2_move)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_sum_reg      <= s1_sum;
            s2_mask_reg     <= s1_mask;
            s2_interior_reg <= s1_interior;
            for (int i = 0; i < 3; i++)
                s2_slot_reg[i] <= s1_slot[i];
        end
    end

    // sum*256/9 by reciprocal multiplication
    assign div_prod = PROD_W'(s2_sum_reg) * PROD_W'(DIV9_MUL);
    assign div_quot = div_prod[DIV9_SHIFT +: HEIGHT_W];

    // Interior centre takes the smoothed height
    always_comb
    begin
        s2_res0 = s2_slot_reg[0];
        if (s2_interior_reg)
            s2_res0.height = div_quot;
    end

    // Output stage: pending mask, lowest slot first
    always_comb
    begin
        if (pend_reg[0])
            out_slot = res_slot_reg[0];
        else if (pend_reg[1])
            out_slot = res_slot_reg[1];
        else
            out_slot = res_slot_reg[2];
        pend_next = pend_reg & (pend_reg - 3'b001);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'b000;
        else if (s2_move)
            pend_reg <= s2_mask_reg;
        else if (out_fire)
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            res_slot_reg[0] <= s2_res0;
            res_slot_reg[1] <= s2_slot_reg[1];
            res_slot_reg[2] <= s2_slot_reg[2];
        end
    end

    assign out_valid    = (pend_reg != 3'b000);
    assign column       = out_slot.col;
    assign row          = out_slot.row;
    assign height_fixed = out_slot.height;
    assign is_border    = out_slot.border;
    assign last         = (pend_next == 3'b000);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // same-cycle write-back and read never hit the same line store entry
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && in_fire) |-> (s1_x_reg != col_cnt_reg))
        else $error("line store read and write collide");

    // raster position stays inside the map
    a_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_cnt_reg} < w_eff) || $past(cfg_hit))
        else $error("column counter outside map");

    a_row_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, row_cnt_reg} < h_eff) || $past(cfg_hit))
        else $error("row counter outside map");

    // after the final result of a sample nothing is shown unless refilled
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last && !s2_move) |=> !out_valid)
        else $error("result shown after last transaction");

    // stage 1 never overwritten while it cannot retire
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> (s1_valid_reg && $stable(s1_x_reg)))
        else $error("stage 1 lost while stalled");

endmodule

// ===== tb/heightmap_box_smoothing_3x3_checker.sv =====
// ----------------------------------------------------------------------------
// Height-map 3x3 smoothing checker
// Watches the configuration, sample and result channels of the smoothing
// unit, keeps its own copy of the line stores, window and counters, works
// out the vertices each accepted sample releases and compares every result
// transaction, field by field, with the oldest vertex still awaited.
// ----------------------------------------------------------------------------
module heightmap_box_smoothing_3x3_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbs_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [hbs_pkg::COL_W-1:0]     column,
    input  logic [hbs_pkg::ROW_W-1:0]     row,
    input  logic [hbs_pkg::HEIGHT_W-1:0]  height_fixed,
    input  logic                          is_border,
    input  logic                          last,
    output int                            error_count,
    output int                            pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import hbs_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic [HEIGHT_W-1:0] height;
        logic                border;
        logic                last;
    } vertex_t;

    // Shadow of the smoothing state
    logic [SAMPLE_W-1:0] row_two_up [MAX_WIDTH];
    logic [SAMPLE_W-1:0] row_one_up [MAX_WIDTH];
    logic [SAMPLE_W-1:0] window_px [6];   // [0..2] column x-2, [3..5] column x-1
    int unsigned         next_col;
    int unsigned         next_row;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;

    vertex_t awaited_vertices [$];
    int      mismatches;

    assign error_count = mismatches;

    function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] raw,
                                               input int unsigned maxv);
        if (raw < MIN_SIZE)
            return 3;
        if (raw > maxv)
            return maxv;
        return raw;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            mismatches++;
        end
    endtask

    // Vertices released by one sample, then the state update
    task automatic smooth_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned         w;
        int unsigned         h;
        int unsigned         x;
        int unsigned         y;
        int unsigned         sum;
        logic [SAMPLE_W-1:0] above2;
        logic [SAMPLE_W-1:0] above1;
        vertex_t             v;
        vertex_t             batch [$];

        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        x = (next_col >= w) ? w - 1 : next_col;
        y = (next_row >= h) ? h - 1 : next_row;
        above2 = row_two_up[x];
        above1 = row_one_up[x];

        // centre of the window, one row and one column behind
        if (y >= 1 && x >= 1)
        begin
            v.column = COL_W'(x - 1);
            v.row    = ROW_W'(y - 1);
            v.last   = 1'b0;
            if (x == 1 || y == 1)
            begin
                v.height = {window_px[4], 8'h00};
                v.border = 1'b1;
            end
            else
            begin
                sum = above2 + above1 + s;
                for (int i = 0; i < 6; i++)
                    sum += window_px[i];
                v.height = HEIGHT_W'((sum << 8) / 9);
                v.border = 1'b0;
            end
            batch = {batch, v};
        end
        // right-hand edge of the row above
        if (y >= 1 && x == w - 1)
        begin
            v.column = COL_W'(x);
            v.row    = ROW_W'(y - 1);
            v.height = {above1, 8'h00};
            v.border = 1'b1;
            v.last   = 1'b0;
            batch = {batch, v};
        end
        // bottom row passes straight through
        if (y == h - 1)
        begin
            v.column = COL_W'(x);
            v.row    = ROW_W'(y);
            v.height = {s, 8'h00};
            v.border = 1'b1;
            v.last   = 1'b0;
            batch = {batch, v};
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            awaited_vertices = {awaited_vertices, batch[i]};

        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = above2;
        window_px[4] = above1;
        window_px[5] = s;
        row_two_up[x] = above1;
        row_one_up[x] = s;

        if (x + 1 >= w)
        begin
            next_col = 0;
            next_row = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            next_col = x + 1;
            next_row = y;
        end
    endtask

    // Channel monitor: results first, then register writes, then samples
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                row_two_up[i] = '0;
                row_one_up[i] = '0;
            end
            for (int i = 0; i < 6; i++)
                window_px[i] = '0;
            next_col   = 0;
            next_row   = 0;
            width_reg  = RESET_SIZE;
            height_reg = RESET_SIZE;
            awaited_vertices.delete();
            mismatches = 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_vertices.size() == 0)
                begin
                    $error("result transaction with nothing awaited: column %0d row %0d",
                           column, row);
                    mismatches++;
                end
                else
                begin
                    want = awaited_vertices.pop_front();
                    check_field("column", want.column, column);
                    check_field("row", want.row, row);
                    check_field("height_fixed", want.height, height_fixed);
                    check_field("is_border", want.border, is_border);
                    check_field("last", want.last, last);
                end
            end

            // a size write also restarts the map
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAP_WIDTH)
                begin
                    width_reg = cfg_data;
                    next_col  = 0;
                    next_row  = 0;
                end
                else if (cfg_index == REG_MAP_HEIGHT)
                begin
                    height_reg = cfg_data;
                    next_col   = 0;
                    next_row   = 0;
                end
            end

            if (in_valid && !in_stall)
                smooth_sample(sample);

            pending_results <= awaited_vertices.size();
        end
    end

endmodule

// ===== tb/heightmap_box_smoothing_3x3_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Height-map 3x3 smoothing unit testbench
// Drives register writes and raster samples into the unit with random gaps
// and output stalls: a short directed run over the smallest map, then random
// small maps, then the opening samples of maps at the largest width and height.
// The checker beside the unit predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module heightmap_box_smoothing_3x3_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ITEMS    = 150;
    localparam int EDGE_MAP_ITEMS  = 12;
    localparam longint TIMEOUT_NS  = 40_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
    logic [SIZE_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COL_W-1:0]     column;
    logic [ROW_W-1:0]     row;
    logic [HEIGHT_W-1:0]  height_fixed;
    logic                 is_border;
    logic                 last;
    int                   error_count;
    int                   pending_results;

    // stretches with no idling on either side
    logic                 calm       = 1'b0;
    int                   stall_hold = 0;

    always #5 clk = ~clk;

    heightmap_box_smoothing_3x3_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column       (column),
        .row          (row),
        .height_fixed (height_fixed),
        .is_border    (is_border),
        .last         (last)
    );

    heightmap_box_smoothing_3x3_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .column          (column),
        .row             (row),
        .height_fixed    (height_fixed),
        .is_border       (is_border),
        .last            (last),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // Output back-pressure in bursts, mostly short
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= !calm && ($urandom_range(0, 99) < 40);
            stall_hold <= ($urandom_range(0, 11) == 0) ? $urandom_range(8, 20)
                                                       : $urandom_range(0, 2);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_height();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return SAMPLE_W'($urandom_range(0, 255));
    endfunction

    function automatic int effective_size(input logic [SIZE_W-1:0] raw,
                                          input int maxv);
        if (raw < MIN_SIZE)
            return 3;
        if (raw > maxv)
            return maxv;
        return raw;
    endfunction

    // One sample transaction, after an optional gap
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // Register write; valid stays high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // Stop sending until every awaited vertex is out and the pipe is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_maps(input logic [SIZE_W-1:0] raw_w,
                             input logic [SIZE_W-1:0] raw_h,
                             input int count);
        write_reg(REG_MAP_WIDTH, raw_w);
        write_reg(REG_MAP_HEIGHT, raw_h);
        end_writes();
        for (int i = 0; i < count; i++)
            push_sample(random_height());
        drain_results();
    endtask

    // Stimulus
    initial
    begin
        logic [SAMPLE_W-1:0] mixed [9];
        logic [SIZE_W-1:0]   raw_w;
        logic [SIZE_W-1:0]   raw_h;
        int                  random_items;
        int                  map_px;
        int                  count;

        mixed = '{8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h81, 8'h7E, 8'h01, 8'h80, 8'hFE};
        random_items = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest map, full-scale heights
        write_reg(REG_MAP_WIDTH, SIZE_W'(3));
        write_reg(REG_MAP_HEIGHT, SIZE_W'(3));
        end_writes();
        for (int i = 0; i < 9; i++)
            push_sample('1);
        // second map straight after the wrap, alternating floor and peak
        for (int i = 0; i < 9; i++)
            push_sample((i % 2) ? '1 : '0);
        // a write to an unused index must leave the map position alone
        for (int i = 0; i < 4; i++)
            push_sample(mixed[i]);
        drain_results();
        write_reg(REG_SPARE, SIZE_W'(5));
        end_writes();
        for (int i = 4; i < 9; i++)
            push_sample(mixed[i]);
        // sizes rewritten part way into a map, below the minimum
        push_sample(8'h3C);
        push_sample(8'hC3);
        drain_results();
        write_reg(REG_MAP_WIDTH, SIZE_W'(0));
        write_reg(REG_MAP_HEIGHT, SIZE_W'(2));
        end_writes();
        for (int i = 0; i < 9; i++)
            push_sample(random_height());
        drain_results();

        // random small maps, some cut short
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: raw_w = SIZE_W'($urandom_range(0, 2));
                3, 4, 5, 6, 7: raw_w = SIZE_W'($urandom_range(9, 20));
                default: raw_w = SIZE_W'($urandom_range(3, 8));
            endcase
            raw_h = ($urandom_range(0, 5) == 0) ? SIZE_W'($urandom_range(0, 2))
                                                : SIZE_W'($urandom_range(3, 6));
            calm <= ($urandom_range(0, 4) == 0);
            map_px = effective_size(raw_w, MAX_WIDTH) * effective_size(raw_h, MAX_HEIGHT);
            count = $urandom_range(1, 2) * map_px;
            if ($urandom_range(0, 3) == 0)
                count = count - $urandom_range(1, map_px - 1);
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;

            write_reg(REG_MAP_WIDTH, raw_w);
            write_reg(REG_MAP_HEIGHT, raw_h);
            end_writes();
            for (int i = 0; i < count; i++)
            begin
                push_sample(random_height());
                random_items++;
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
            drain_results();
        end

        // widest map (clamped from above), then tallest map: opening samples
        calm <= 1'b0;
        send_maps(SIZE_W'(2047), SIZE_W'(3), EDGE_MAP_ITEMS);
        send_maps(SIZE_W'(3), SIZE_W'(MAX_HEIGHT), EDGE_MAP_ITEMS);

        drain_results();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hbs_pkg.sv
design/heightmap_box_smoothing_3x3_unit.sv
tb/heightmap_box_smoothing_3x3_checker.sv
tb/heightmap_box_smoothing_3x3_unit_tb.sv
